FILE: rtl/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types and codes for the overwriting ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

  localparam int OP_W  = 2;
  localparam int CFG_W = 7;
  localparam int RMV_W = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  typedef struct packed {
    logic do_cfg;
    logic do_append;
    logic do_remove;
    logic do_list_load;
    logic do_read;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic read_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/overwriting_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_core
// Ring buffer of entry words that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries append, remove and list items.
// Append and remove produce no output; back-to-back
// appends and removes are accepted every cycle.
// A list on a buffer holding n entries stalls the input while its n entries
// are read out: the read pointer loads at the accepting edge, then one memory
// read per cycle through the single read port while the output is free. The
// first entry is registered onto entry_out by the first read; last_of_list
// marks the newest entry. A list on an empty buffer produces no output.
// Output stall holds the current transfer and pauses the read-out; the input
// stays stalled until the last read is issued.
// Config channel (cfg_valid / cfg_ready) writes capacity_in_use (0 acts as 1,
// above DEPTH acts as DEPTH) and empties the buffer; it is ready only when no
// list is running and no input item is offered. Reset empties the buffer and
// sets the capacity to DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_buffer_core #(
  parameter int DEPTH       = 64,
  parameter int ENTRY_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [orb_pkg::OP_W-1:0]    operation,
  input  wire logic [ENTRY_WIDTH-1:0]      entry_value,
  input  wire logic [orb_pkg::RMV_W-1:0]   remove_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ENTRY_WIDTH-1:0]           entry_out,
  output logic                             last_of_list,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [orb_pkg::CFG_W-1:0]   capacity_in_use
);

  orb_pkg::cmd_t    cmd;
  orb_pkg::status_t status;

  orb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  orb_datapath #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .capacity_in_use (capacity_in_use),
    .entry_value     (entry_value),
    .remove_count    (remove_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .entry_out       (entry_out),
    .last_of_list    (last_of_list)
  );

endmodule

`default_nettype wire

FILE: rtl/orb_ctrl.sv
// ----------------------------------------------------------------------------
// orb_ctrl
// Controller: grants config, decodes accepted items and sequences the list read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [orb_pkg::OP_W-1:0]   operation,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire orb_pkg::status_t           status,
  output orb_pkg::cmd_t                   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic state;
  logic state_next;
  logic in_fire;
  logic cfg_fire;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !in_valid;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cfg_fire) begin
          cmd.do_cfg = 1'b1;
        end else if (in_fire) begin
          case (operation)
            orb_pkg::OP_APPEND: cmd.do_append = 1'b1;
            orb_pkg::OP_REMOVE: cmd.do_remove = 1'b1;
            orb_pkg::OP_LIST: begin
              if (!status.empty) begin
                cmd.do_list_load = 1'b1;
                state_next       = ST_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        if (status.out_free) begin
          cmd.do_read = 1'b1;
          if (status.read_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/orb_datapath.sv
// ----------------------------------------------------------------------------
// orb_datapath
// Ring pointers, entry memory, list read pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_datapath #(
  parameter int DEPTH       = 64,
  parameter int ENTRY_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire orb_pkg::cmd_t               cmd,
  output orb_pkg::status_t                 status,
  input  wire logic [orb_pkg::CFG_W-1:0]   capacity_in_use,
  input  wire logic [ENTRY_WIDTH-1:0]      entry_value,
  input  wire logic [orb_pkg::RMV_W-1:0]   remove_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ENTRY_WIDTH-1:0]           entry_out,
  output logic                             last_of_list
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > orb_pkg::CFG_W) ? CNT_W : orb_pkg::CFG_W;
  localparam logic [CNT_W-1:0] CAP_MAX  = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  logic [CNT_W-1:0] cap;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] newest;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] remaining;

  logic [CNT_W-1:0] cap_cfg;
  logic [CNT_W-1:0] newest_inc;
  logic [IDX_W-1:0] newest_wrap;
  logic [CNT_W-1:0] oldest_inc;
  logic [IDX_W-1:0] oldest_wrap;
  logic [CNT_W-1:0] pos_inc;
  logic [IDX_W-1:0] pos_wrap;
  logic             rmv_all;
  logic [CNT_W-1:0] rmv_k;
  logic [CNT_W:0]   rmv_sum;
  logic [IDX_W-1:0] rmv_wrap;

  always_comb begin
    if (capacity_in_use == '0) begin
      cap_cfg = CNT_W'(1);
    end else if (CMP_W'(capacity_in_use) > CMP_W'(CAP_MAX)) begin
      cap_cfg = CAP_MAX;
    end else begin
      cap_cfg = CNT_W'(capacity_in_use);
    end
  end

  assign newest_inc  = CNT_W'(newest) + CNT_W'(1);
  assign newest_wrap = (newest_inc >= cap) ? '0 : IDX_W'(newest_inc);
  assign oldest_inc  = CNT_W'(oldest) + CNT_W'(1);
  assign oldest_wrap = (oldest_inc >= cap) ? '0 : IDX_W'(oldest_inc);
  assign pos_inc     = CNT_W'(pos) + CNT_W'(1);
  assign pos_wrap    = (pos_inc >= cap) ? '0 : IDX_W'(pos_inc);

  assign rmv_all  = CMP_W'(remove_count) >= CMP_W'(count);
  assign rmv_k    = CNT_W'(remove_count);
  assign rmv_sum  = (CNT_W+1)'(oldest) + (CNT_W+1)'(rmv_k);
  assign rmv_wrap = (rmv_sum >= (CNT_W+1)'(cap)) ? IDX_W'(rmv_sum - (CNT_W+1)'(cap))
                                                 : IDX_W'(rmv_sum);

  assign status.empty     = (count == '0);
  assign status.read_last = (remaining == CNT_W'(1));
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_MAX;
      oldest    <= '0;
      newest    <= IDX_LAST;
      count     <= '0;
      pos       <= '0;
      remaining <= '0;
    end else begin
      if (cmd.do_cfg) begin
        cap    <= cap_cfg;
        oldest <= '0;
        newest <= IDX_W'(cap_cfg - CNT_W'(1));
        count  <= '0;
      end
      if (cmd.do_append) begin
        newest <= newest_wrap;
        if (count >= cap) begin
          oldest <= oldest_wrap;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.do_remove) begin
        if (rmv_all) begin
          oldest <= '0;
          newest <= IDX_W'(cap - CNT_W'(1));
          count  <= '0;
        end else begin
          oldest <= rmv_wrap;
          count  <= count - rmv_k;
        end
      end
      if (cmd.do_list_load) begin
        pos       <= oldest;
        remaining <= count;
      end
      if (cmd.do_read) begin
        pos       <= pos_wrap;
        remaining <= remaining - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_append) begin
      mem[newest_wrap] <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_read) begin
      entry_out    <= mem[pos];
      last_of_list <= status.read_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/orb_checker.sv
// ----------------------------------------------------------------------------
// orb_checker
// Port-level checks for the overwriting ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_checker #(
  parameter int ENTRY_WIDTH = 64
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [ENTRY_WIDTH-1:0] entry_out,
  input wire logic                   last_of_list,
  input wire logic                   cfg_ready
);

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // config is taken only when no list is running
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("config ready during list");

  // a non-final list entry means the read-out is still running
  a_list_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_list |-> in_stall)
    else $error("input open before list finished");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_out) && $stable(last_of_list))
    else $error("stalled output transfer changed");

endmodule

bind overwriting_ring_buffer_core orb_checker #(
  .ENTRY_WIDTH (ENTRY_WIDTH)
) u_orb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .entry_out    (entry_out),
  .last_of_list (last_of_list),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
